### hdl/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and constants for the header tagged bump allocator.
// ----------------------------------------------------------------------------
package hba_pkg;

  localparam int ARENA_BYTES_DEF = 65536;
  localparam int MAX_ALIGN_DEF   = 256;

  localparam logic [31:0] FREED_BIT = 32'h8000_0000;
  localparam logic [31:0] SIZE_MASK = 32'h7fff_ffff;
  localparam int          WORD_BYTES = 4;

  localparam logic [16:0] ARENA_SIZE_RST = 17'd65536;
  localparam logic [31:0] PAD_WORD_RST   = 32'hffff_ffff;

  localparam logic REG_ARENA_SIZE = 1'b0;
  localparam logic REG_PAD_WORD   = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_BAD_REQ   = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_DBL_FREE  = 3'd4;
  localparam logic [2:0] ST_NULL      = 3'd5;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  status;
    logic [16:0] request_bytes;
    logic [8:0]  align_bytes;
    logic [15:0] block_offset;
  } cmd_t;

  typedef struct packed {
    logic [15:0] data_offset;
    logic [2:0]  status;
    logic [16:0] bytes_in_use;
    logic [14:0] live_blocks;
    logic [16:0] reclaim_offset;
  } result_t;

endpackage

### hdl/header_tagged_bump_allocator_core.sv
// ----------------------------------------------------------------------------
// header_tagged_bump_allocator_core
// Arena allocator with tagged block headers over a word RAM.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    operation request_bytes align_bytes block_offset
// out      out  out_valid/out_ready  data_offset status bytes_in_use live_blocks
//                                    reclaim_offset
// cfg      in   cfg_valid/cfg_ready  cfg_index cfg_data
//
// allocate: alignment remainder one bit at a time, rounding, end check, header write,
// one write per pad word, then the result; exhausted ends after the end check, and
// rejected words go straight to the result. free: pad walk, freed marking, then reclaim
// advance over freed blocks until it stops short of or reaches the allocation pointer
// reset is synchronous; arena contents are not cleared
// the queue takes up to two words while the engine is busy or the result stalls
module header_tagged_bump_allocator_core #(
  parameter int ARENA_BYTES = hba_pkg::ARENA_BYTES_DEF,
  parameter int MAX_ALIGN   = hba_pkg::MAX_ALIGN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [16:0] request_bytes,
  input  logic [8:0]  align_bytes,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] data_offset,
  output logic [2:0]  status,
  output logic [16:0] bytes_in_use,
  output logic [14:0] live_blocks,
  output logic [16:0] reclaim_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [24:0] ARENA_L = 25'(ARENA_BYTES);

  logic [16:0]      arena_size;
  logic [31:0]      pad_word;
  logic [16:0]      limit;
  logic             push_valid;
  logic             push_ready;
  hba_pkg::cmd_t    push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  hba_pkg::cmd_t    pop_cmd;
  hba_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign limit = ({8'd0, arena_size} > ARENA_L) ? ARENA_L[16:0] : arena_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size <= hba_pkg::ARENA_SIZE_RST;
      pad_word   <= hba_pkg::PAD_WORD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hba_pkg::REG_ARENA_SIZE: arena_size <= cfg_data[16:0];
        hba_pkg::REG_PAD_WORD:   pad_word   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hba_front #(.MAX_ALIGN(MAX_ALIGN)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .request_bytes (request_bytes),
    .align_bytes   (align_bytes),
    .block_offset  (block_offset),
    .limit         (limit),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  hba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  hba_back #(.ARENA_BYTES(ARENA_BYTES), .MAX_ALIGN(MAX_ALIGN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .limit     (limit),
    .pad_word  (pad_word),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign data_offset    = res.data_offset;
  assign status         = res.status;
  assign bytes_in_use   = res.bytes_in_use;
  assign live_blocks    = res.live_blocks;
  assign reclaim_offset = res.reclaim_offset;

endmodule

### hdl/hba_ram.sv
// ----------------------------------------------------------------------------
// hba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/hba_front.sv
// ----------------------------------------------------------------------------
// hba_front
// Request checks: sorts each input word into allocate, free or reject.
// ----------------------------------------------------------------------------
module hba_front #(
  parameter int MAX_ALIGN = hba_pkg::MAX_ALIGN_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [16:0]       request_bytes,
  input  logic [8:0]        align_bytes,
  input  logic [15:0]       block_offset,
  input  logic [16:0]       limit,
  output logic              push_valid,
  input  logic              push_ready,
  output hba_pkg::cmd_t     push_cmd
);

  logic align_bad;

  assign align_bad = (align_bytes == 9'd0) || (align_bytes[1:0] != 2'b00) ||
                     ({4'b0, align_bytes} > 13'(MAX_ALIGN));

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.request_bytes = request_bytes;
    push_cmd.align_bytes   = align_bytes;
    push_cmd.block_offset  = block_offset;
    push_cmd.status        = hba_pkg::ST_OK;
    push_cmd.kind          = hba_pkg::CMD_REJECT;
    if (operation == hba_pkg::OP_ALLOC) begin
      if (request_bytes == 17'd0 || align_bad) begin
        push_cmd.status = hba_pkg::ST_BAD_REQ;
      end else begin
        push_cmd.kind = hba_pkg::CMD_ALLOC;
      end
    end else begin
      priority if (block_offset == 16'd0) begin
        push_cmd.status = hba_pkg::ST_NULL;
      end else if (block_offset[1:0] != 2'b00) begin
        push_cmd.status = hba_pkg::ST_BAD_REQ;
      end else if ({1'b0, block_offset} >= limit) begin
        push_cmd.status = hba_pkg::ST_OUTSIDE;
      end else begin
        push_cmd.kind = hba_pkg::CMD_FREE;
      end
    end
  end

endmodule

### hdl/hba_queue.sv
// ----------------------------------------------------------------------------
// hba_queue
// Two entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module hba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  hba_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hba_pkg::cmd_t pop_cmd
);

  hba_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hdl/hba_back.sv
// ----------------------------------------------------------------------------
// hba_back
// Allocator engine: alignment remainder, header and pad writes, pad walk,
// freed marking and reclaim advance, with the result register.
// ----------------------------------------------------------------------------
module hba_back #(
  parameter int ARENA_BYTES = hba_pkg::ARENA_BYTES_DEF,
  parameter int MAX_ALIGN   = hba_pkg::MAX_ALIGN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  hba_pkg::cmd_t    cmd,
  input  logic [16:0]      limit,
  input  logic [31:0]      pad_word,
  output logic             res_valid,
  input  logic             res_ready,
  output hba_pkg::result_t res
);

  localparam int DEPTH    = ARENA_BYTES / hba_pkg::WORD_BYTES;
  localparam int AW       = $clog2(DEPTH);
  localparam int MAX_STEP = MAX_ALIGN / hba_pkg::WORD_BYTES - 1;
  localparam int SW       = $clog2(MAX_ALIGN / hba_pkg::WORD_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ROUND, S_END, S_HDR, S_PAD,
    S_WRD, S_WCHK, S_MARK, S_RRD, S_RCHK, S_FIN
  } state_t;

  state_t      state;
  logic [17:0] size;
  logic [8:0]  align;
  logic [16:0] head;
  logic [16:0] dat;
  logic [9:0]  rem;
  logic [4:0]  bitc;
  logic [18:0] endo;
  logic [16:0] pw;
  logic [14:0] w;
  logic [SW-1:0] steps;
  logic [31:0] hdr;
  logic [2:0]  st;
  logic [15:0] dout;
  logic [16:0] nap;
  logic [16:0] frp;
  logic [16:0] used;
  logic [14:0] cnt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [9:0]    rem_shift;
  logic [9:0]    rem_next;
  logic [30:0]   sz;
  logic          res_take;

  function automatic logic [AW-1:0] widx(input logic [16:0] off);
    return AW'(off >> 2);
  endfunction

  hba_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign rem_shift = {rem[8:0], dat[bitc]};
  assign rem_next  = (rem_shift >= {1'b0, align}) ? rem_shift - {1'b0, align} : rem_shift;
  assign sz        = ram_rdata[30:0];
  assign res_take  = (state == S_FIN) && (!res_valid || res_ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx(head);
    ram_wdata = 32'(endo - {2'b0, head});
    ram_raddr = widx(frp);
    unique case (state)
      S_HDR: begin
        ram_we = 1'b1;
      end
      S_PAD: begin
        ram_we    = (pw < dat);
        ram_waddr = widx(pw);
        ram_wdata = pad_word;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(w - 15'd1);
        ram_wdata = hdr | hba_pkg::FREED_BIT;
      end
      S_WRD: begin
        ram_raddr = AW'(w - 15'd1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nap       <= 17'd0;
      frp       <= 17'd0;
      used      <= 17'd0;
      cnt       <= 15'd0;
      res_valid <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            dout <= 16'd0;
            unique case (cmd.kind)
              hba_pkg::CMD_ALLOC: begin
                size  <= ({1'b0, cmd.request_bytes} + 18'd3) & ~18'd3;
                align <= cmd.align_bytes;
                head  <= nap;
                dat   <= nap + 17'd4;
                rem   <= 10'd0;
                bitc  <= 5'd16;
                state <= S_DIV;
              end
              hba_pkg::CMD_FREE: begin
                w     <= {1'b0, cmd.block_offset[15:2]};
                steps <= '0;
                state <= S_WRD;
              end
              default: begin
                st    <= cmd.status;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_DIV: begin
          rem <= rem_next;
          if (bitc == 5'd0) begin
            state <= S_ROUND;
          end else begin
            bitc <= bitc - 5'd1;
          end
        end
        S_ROUND: begin
          if (rem != 10'd0) begin
            dat <= dat + 17'({1'b0, align} - rem);
          end
          state <= S_END;
        end
        S_END: begin
          endo <= {2'b0, dat} + {1'b0, size};
          if (({2'b0, dat} + {1'b0, size}) > {2'b0, limit}) begin
            st    <= hba_pkg::ST_EXHAUSTED;
            state <= S_FIN;
          end else begin
            state <= S_HDR;
          end
        end
        S_HDR: begin
          pw    <= head + 17'd4;
          state <= S_PAD;
        end
        S_PAD: begin
          if (pw < dat) begin
            pw <= pw + 17'd4;
          end else begin
            nap  <= endo[16:0];
            used <= used + 17'(endo - {2'b0, head});
            if (cnt != 15'h7fff) begin
              cnt <= cnt + 15'd1;
            end
            dout  <= dat[15:0];
            st    <= hba_pkg::ST_OK;
            state <= S_FIN;
          end
        end
        S_WRD: begin
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (w > 15'd1 && steps < SW'(MAX_STEP) && ram_rdata == pad_word) begin
            w     <= w - 15'd1;
            steps <= steps + 1'b1;
            state <= S_WRD;
          end else begin
            hdr <= ram_rdata;
            if (ram_rdata[31]) begin
              st    <= hba_pkg::ST_DBL_FREE;
              state <= S_FIN;
            end else begin
              used  <= (ram_rdata > {15'd0, used}) ? 17'd0 : used - ram_rdata[16:0];
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          if (cnt != 15'd0) begin
            cnt <= cnt - 15'd1;
          end
          state <= S_RRD;
        end
        S_RRD: begin
          if (frp < nap) begin
            state <= S_RCHK;
          end else begin
            st    <= hba_pkg::ST_OK;
            state <= S_FIN;
          end
        end
        S_RCHK: begin
          if (!ram_rdata[31] || sz == 31'd0 || sz[1:0] != 2'b00 ||
              sz > {14'd0, nap - frp}) begin
            st    <= hba_pkg::ST_OK;
            state <= S_FIN;
          end else begin
            frp   <= frp + sz[16:0];
            state <= S_RRD;
          end
        end
        S_FIN: begin
          if (res_take) begin
            res.data_offset    <= dout;
            res.status         <= st;
            res.bytes_in_use   <= used;
            res.live_blocks    <= cnt;
            res.reclaim_offset <= frp;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_frp_le_nap: assert property (@(posedge clk) disable iff (rst) frp <= nap)
    else $error("reclaim pointer passed allocation pointer");
  a_used_le_nap: assert property (@(posedge clk) disable iff (rst) used <= nap)
    else $error("bytes in use exceed allocated span");
  a_nap_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> nap >= $past(nap))
    else $error("allocation pointer moved back");

endmodule
